FILE: hdl/fsfl_pkg.sv
package fsfl_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = 10;
  localparam int COUNT_W   = $clog2(SLOTS + 1);
  localparam int MODE_W    = 2;
  localparam int EBYTES_W  = 13;
  localparam int OFFSET_W  = 22;

  localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE_ALL = 2'd2;

  localparam logic [EBYTES_W-1:0] EBYTES_RESET = 13'd8;

  // One entry of the free-list link memory.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] next;
  } link_t;

  // Decision of the allocator stage, handed to the offset stage.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              status;
  } grant_t;

endpackage

FILE: hdl/fsfl_req_if.sv
interface fsfl_req_if;
  import fsfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, output mode, output slot_in, input ready);
  modport sink   (input valid, input mode, input slot_in, output ready);
endinterface

FILE: hdl/fsfl_rsp_if.sv
interface fsfl_rsp_if;
  import fsfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_out;
  logic [OFFSET_W-1:0] byte_offset;
  logic                status;

  modport source (output valid, output slot_out, output byte_offset, output status,
                  input ready);
  modport sink   (input valid, input slot_out, input byte_offset, input status,
                  output ready);
endinterface

FILE: hdl/fsfl_link_ram.sv
module fsfl_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fsfl_alloc_core.sv
module fsfl_alloc_core (
  input  logic            clk,
  input  logic            rst,
  fsfl_req_if.sink        req,
  output logic            grant_valid,
  output fsfl_pkg::grant_t grant,
  input  logic            grant_ready
);
  import fsfl_pkg::*;

  logic               accept;
  logic [SLOT_W-1:0]  head, head_next;
  logic               nonempty, nonempty_next;
  logic [COUNT_W-1:0] fresh_count, fresh_count_next;

  // Cached link entry of the current head, so a pop needs no memory wait.
  link_t              head_link, head_link_next;
  logic               link_pending;
  link_t              link_eff;
  grant_t             grant_d;

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  link_t              ram_wdata;
  logic [$bits(link_t)-1:0] ram_rdata;

  fsfl_link_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(link_t))
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = !grant_valid || grant_ready;
  assign accept    = req.valid && req.ready;

  // After a pop the link of the new head arrives from the memory in the following cycle.
  assign link_eff = link_pending ? link_t'(ram_rdata) : head_link;

  always_comb begin
    head_next        = head;
    nonempty_next    = nonempty;
    fresh_count_next = fresh_count;
    head_link_next   = link_eff;
    grant_d          = '0;
    ram_we           = 1'b0;
    ram_waddr        = req.slot_in;
    ram_wdata        = '{valid: nonempty, next: head};
    ram_re           = 1'b0;
    ram_raddr        = link_eff.next;
    if (accept) begin
      case (req.mode)
        MODE_ALLOC: begin
          if (nonempty) begin
            grant_d.slot  = head;
            head_next     = link_eff.next;
            nonempty_next = link_eff.valid;
            ram_re        = 1'b1;
          end else if (fresh_count < COUNT_W'(SLOTS)) begin
            grant_d.slot     = fresh_count[SLOT_W-1:0];
            fresh_count_next = fresh_count + COUNT_W'(1);
          end else begin
            grant_d.status = 1'b1;
          end
        end
        MODE_FREE: begin
          if (COUNT_W'(req.slot_in) < COUNT_W'(SLOTS)) begin
            ram_we         = 1'b1;
            head_next      = req.slot_in;
            nonempty_next  = 1'b1;
            head_link_next = '{valid: nonempty, next: head};
          end
        end
        MODE_FREE_ALL: begin
          head_next        = '0;
          nonempty_next    = 1'b0;
          fresh_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      nonempty     <= 1'b0;
      fresh_count  <= '0;
      link_pending <= 1'b0;
      grant_valid  <= 1'b0;
    end else begin
      head         <= head_next;
      nonempty     <= nonempty_next;
      fresh_count  <= fresh_count_next;
      link_pending <= ram_re;
      if (req.ready) begin
        grant_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_link <= head_link_next;
    if (req.ready) begin
      grant <= grant_d;
    end
  end

  a_fresh_bounded: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= COUNT_W'(SLOTS))
    else $error("bump counter ran past the pool size");

  a_free_sets_head: assert property (@(posedge clk) disable iff (rst)
    accept && req.mode == MODE_FREE |=> nonempty && head == $past(req.slot_in))
    else $error("freed slot did not become the list head");

  a_grant_held: assert property (@(posedge clk) disable iff (rst)
    grant_valid && !grant_ready |=> grant_valid && $stable(grant))
    else $error("stalled grant changed");

  a_fail_only_when_exhausted: assert property (@(posedge clk) disable iff (rst)
    accept && req.mode == MODE_ALLOC && (nonempty || fresh_count != COUNT_W'(SLOTS))
    |=> !grant.status)
    else $error("allocate failed with slots still available");

endmodule

FILE: hdl/fsfl_offset_stage.sv
module fsfl_offset_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          grant_valid,
  input  fsfl_pkg::grant_t              grant,
  output logic                          grant_ready,
  input  logic [fsfl_pkg::EBYTES_W-1:0] element_bytes,
  fsfl_rsp_if.source                    rsp
);
  import fsfl_pkg::*;

  logic [SLOT_W+EBYTES_W-1:0] product;

  assign grant_ready = !rsp.valid || rsp.ready;
  assign product     = grant.slot * element_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (grant_ready) begin
      rsp.valid <= grant_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (grant_ready) begin
      rsp.slot_out    <= grant.slot;
      rsp.byte_offset <= product[OFFSET_W-1:0];
      rsp.status      <= grant.status;
    end
  end

endmodule

FILE: hdl/fixed_slot_free_list_allocator_unit.sv
// Pool allocator for fixed-size slots with a LIFO free list.
//
// Requests enter on req (mode, slot_in); every request yields exactly one
// result item on rsp (slot_out, byte_offset, status), in request order.
// An allocate pops the most recently freed slot, or else takes the next
// never-used slot; when both are exhausted it returns status 1. A free
// pushes slot_in, and a free-all empties the list and rewinds the counter.
// cfg_we/cfg_wdata set the slot size in bytes used for byte_offset.
//
// Results pass through the grant register and then the response register.
// One item is accepted every cycle unless the result side stalls; the
// link of the current head is cached in a register, so successive pops
// do not wait on the link memory read.
// Reset empties the free list, zeroes the counter and sets the slot size
// to 8 bytes; the link memory is not cleared and the block is ready at once.
// Two result stages sit between the sides, so req stays ready while one
// result waits; req.ready drops only once both stages hold a stalled result.
module fixed_slot_free_list_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fsfl_pkg::EBYTES_W-1:0] cfg_wdata,
  fsfl_req_if.sink                      req,
  fsfl_rsp_if.source                    rsp
);
  import fsfl_pkg::*;

  logic [EBYTES_W-1:0] element_bytes;
  logic                grant_valid;
  logic                grant_ready;
  grant_t              grant;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= EBYTES_RESET;
    end else if (cfg_we) begin
      element_bytes <= cfg_wdata;
    end
  end

  fsfl_alloc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .grant_valid (grant_valid),
    .grant       (grant),
    .grant_ready (grant_ready)
  );

  fsfl_offset_stage u_offset (
    .clk           (clk),
    .rst           (rst),
    .grant_valid   (grant_valid),
    .grant         (grant),
    .grant_ready   (grant_ready),
    .element_bytes (element_bytes),
    .rsp           (rsp)
  );

endmodule
